// File: rtl/sorted_priority_list_macros.svh
// Assertion macros for the RTL file that carries checks.
`ifndef SORTED_PRIORITY_LIST_MACROS_SVH
`define SORTED_PRIORITY_LIST_MACROS_SVH

// Check that is switched off while reset is held.
`define SPL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds during reset.
`define SPL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/spl_pkg.sv
package spl_pkg;

  localparam int KEY_W = 16;
  localparam int PAY_W = 32;
  localparam int OCC_W = 7;
  localparam int STAT_W = 2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } spl_entry_t;

  // Broadcast from the control to every cell of the chain.
  typedef struct packed {
    logic       ins;
    logic       rem;
    logic       head_ins;
    spl_entry_t new_entry;
  } spl_bcast_t;

endpackage

// File: rtl/spl_cell.sv
module spl_cell (
  input  logic               clk,
  input  spl_pkg::spl_bcast_t bc,
  input  logic               occ,
  input  logic               left_shift,
  input  spl_pkg::spl_entry_t left_entry,
  input  spl_pkg::spl_entry_t right_entry,
  output logic               shift,
  output spl_pkg::spl_entry_t entry
);
  import spl_pkg::*;

  spl_entry_t entry_r, entry_nxt;
  logic       take_new;

  // An occupied cell moves up a place when the new key sorts in front of it.
  // Because the chain is sorted, the moving cells always form a tail.
  assign shift    = occ && (bc.head_ins || (entry_r.key > bc.new_entry.key));
  assign take_new = !left_shift && (shift || !occ);

  always_comb begin
    entry_nxt = entry_r;
    if (bc.rem) begin
      entry_nxt = right_entry;
    end else if (bc.ins) begin
      // A cell whose left neighbour moves takes the entry it pushes out, the first free cell included.
      if (left_shift) begin
        entry_nxt = left_entry;
      end else if (take_new) begin
        entry_nxt = bc.new_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// File: rtl/sorted_priority_list.sv
// Channel  Direction  Ports
// in       input      in_valid, in_ready, in_mode, in_key, in_payload
// out      output     out_valid, out_ready, out_status, out_key, out_payload, out_occupancy
//
// Every cell compares its key with the broadcast key in the accepting cycle
// and the chain shifts in place, so a new request can be accepted in every
// cycle while the result register is free or taken.
// The result is registered and appears in the cycle after acceptance.
// Synchronous reset empties the queue; stored entries are not cleared.
// A stalled result holds in_ready low until out_ready takes it.
`include "sorted_priority_list_macros.svh"

module sorted_priority_list #(
  parameter int CAPACITY = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_mode,
  input  logic [spl_pkg::KEY_W-1:0]  in_key,
  input  logic [spl_pkg::PAY_W-1:0]  in_payload,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [spl_pkg::STAT_W-1:0] out_status,
  output logic [spl_pkg::KEY_W-1:0]  out_key,
  output logic [spl_pkg::PAY_W-1:0]  out_payload,
  output logic [spl_pkg::OCC_W-1:0]  out_occupancy
);
  import spl_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]       count_r, count_nxt;
  logic                full, empty, accept;
  logic                rem_empty;
  spl_bcast_t          bc;
  spl_entry_t          ent [CAPACITY];
  logic [CAPACITY-1:0] shift;

  logic                out_valid_r;
  logic [STAT_W-1:0]   out_status_r;
  logic [KEY_W-1:0]    out_key_r;
  logic [PAY_W-1:0]    out_payload_r;
  logic [OCC_W-1:0]    out_occupancy_r;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign full      = (count_r == CW'(CAPACITY));
  assign empty     = (count_r == '0);
  assign rem_empty = accept && (in_mode == MODE_REMOVE) && empty;

  always_comb begin
    bc.ins           = accept && (in_mode == MODE_INSERT) && !full;
    bc.rem           = accept && (in_mode == MODE_REMOVE) && !empty;
    bc.head_ins      = empty || (in_key <= ent[0].key);
    bc.new_entry.key     = in_key;
    bc.new_entry.payload = in_payload;
  end

  always_comb begin
    count_nxt = count_r;
    if (bc.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (bc.rem) begin
      count_nxt = count_r - 1'b1;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic       left_shift;
    spl_entry_t left_entry, right_entry;

    if (i == 0) begin : g_first
      assign left_shift = 1'b0;
      assign left_entry = bc.new_entry;
    end else begin : g_mid
      assign left_shift = shift[i-1];
      assign left_entry = ent[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = ent[i+1];
    end

    spl_cell u_cell (
      .clk         (clk),
      .bc          (bc),
      .occ         (CW'(i) < count_r),
      .left_shift  (left_shift),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .shift       (shift[i]),
      .entry       (ent[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if ((in_mode == MODE_INSERT) && full) begin
        out_status_r <= ST_FULL;
      end else if ((in_mode == MODE_REMOVE) && empty) begin
        out_status_r <= ST_EMPTY;
      end else begin
        out_status_r <= ST_DONE;
      end
      out_key_r       <= bc.rem ? ent[0].key : '0;
      out_payload_r   <= bc.rem ? ent[0].payload : '0;
      out_occupancy_r <= OCC_W'(count_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_key       = out_key_r;
  assign out_payload   = out_payload_r;
  assign out_occupancy = out_occupancy_r;

  `SPL_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid, "result valid after reset")
  `SPL_ASSERT(a_count_bound, count_r <= CW'(CAPACITY), "count above capacity")
  `SPL_ASSERT(a_ins_count, bc.ins |=> count_r == $past(count_r) + 1'b1, "insert lost count")
  `SPL_ASSERT(a_empty_rm, rem_empty |=> out_valid && (out_status == ST_EMPTY), "bad empty remove")
  `SPL_ASSERT(a_sorted, count_r >= CW'(2) |-> ent[0].key <= ent[1].key, "head pair out of order")

endmodule
